// ===== hdl/scfd_pkg.sv =====
package scfd_pkg;

  localparam int unsigned MaxChannels = 4;
  localparam int unsigned NumChannels = 4;
  localparam int unsigned ChW         = $clog2(MaxChannels);
  localparam int unsigned DutyW       = 10;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned CountW      = 8;
  localparam int unsigned DevIdW      = 2;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 10;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);

  // First-byte layout
  localparam int unsigned HdrFlagBit  = 7;
  localparam int unsigned HdrIdHi     = 6;
  localparam int unsigned HdrIdLo     = 5;
  localparam int unsigned HdrChHi     = 4;
  localparam int unsigned HdrChLo     = 3;
  localparam int unsigned HdrValBit   = 0;

  typedef enum logic [CfgIdxW-1:0] {
    RegDeviceId     = 3'd0,
    RegLockEnable   = 3'd1,
    RegDutyMin      = 3'd2,
    RegDutyMax      = 3'd3,
    RegTimeoutTicks = 3'd4
  } reg_idx_e;

  typedef enum logic {
    OpByte = 1'b0,
    OpTick = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CmdNone = 2'd0,
    CmdSet  = 2'd1,
    CmdTick = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [ChW-1:0]   ch;
    logic [ByteW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [DevIdW-1:0] device_id;
    logic              lock_enable;
    logic [DutyW-1:0]  duty_min;
    logic [DutyW-1:0]  duty_max;
    logic [CountW-1:0] timeout_ticks;
  } cfg_t;

  typedef logic [MaxChannels-1:0][DutyW-1:0] duty_vec_t;

  function automatic logic [DutyW-1:0] clamp_duty(logic [DutyW-1:0] v, cfg_t cfg);
    logic [DutyW-1:0] r;
    r = v;
    if (cfg.lock_enable) begin
      if (v < cfg.duty_min) begin
        r = cfg.duty_min;
      end else if (v > cfg.duty_max) begin
        r = cfg.duty_max;
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/scfd_queue.sv =====
module scfd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  scfd_pkg::cmd_t   push_cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output scfd_pkg::cmd_t   pop_cmd_o
);

  scfd_pkg::cmd_t                       mem_q [scfd_pkg::QueueDepth];
  logic [scfd_pkg::QueuePtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [scfd_pkg::QueuePtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [scfd_pkg::QueueCntW-1:0]       count_q, count_d;

  assign full_o    = (count_q == scfd_pkg::QueueCntW'(scfd_pkg::QueueDepth));
  assign empty_o   = (count_q == '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == scfd_pkg::QueuePtrW'(scfd_pkg::QueueDepth - 1)) ? '0
                                                                               : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == scfd_pkg::QueuePtrW'(scfd_pkg::QueueDepth - 1)) ? '0
                                                                               : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== hdl/scfd_front.sv =====
module scfd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  scfd_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_op_i,
  input  logic [scfd_pkg::ByteW-1:0]    in_byte_i,
  output logic                          push_o,
  output scfd_pkg::cmd_t                cmd_o,
  input  logic                          full_i
);

  logic                       have_first_q, have_first_d;
  logic [scfd_pkg::ByteW-1:0] first_byte_q, first_byte_d;
  logic [scfd_pkg::ChW-1:0]   ch;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  assign ch         = first_byte_q[scfd_pkg::HdrChHi:scfd_pkg::HdrChLo];

  // Classify the beat; every beat yields exactly one command.
  always_comb begin
    have_first_d = have_first_q;
    first_byte_d = first_byte_q;
    cmd_o.kind   = scfd_pkg::CmdNone;
    cmd_o.ch     = ch;
    cmd_o.value  = {first_byte_q[scfd_pkg::HdrValBit], in_byte_i[scfd_pkg::ByteW-2:0]};
    if (scfd_pkg::op_e'(in_op_i) == scfd_pkg::OpTick) begin
      cmd_o.kind = scfd_pkg::CmdTick;
    end else if (!have_first_q) begin
      if (in_byte_i[scfd_pkg::HdrFlagBit] &&
          in_byte_i[scfd_pkg::HdrIdHi:scfd_pkg::HdrIdLo] == cfg_i.device_id) begin
        have_first_d = 1'b1;
        first_byte_d = in_byte_i;
      end
    end else begin
      // Frame addressing a missing channel is consumed without effect.
      if (int'(ch) < scfd_pkg::NumChannels) begin
        cmd_o.kind = scfd_pkg::CmdSet;
      end
      have_first_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_first_q <= 1'b0;
      first_byte_q <= '0;
    end else if (push_o) begin
      have_first_q <= have_first_d;
      first_byte_q <= first_byte_d;
    end
  end

endmodule

// ===== hdl/scfd_back.sv =====
module scfd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scfd_pkg::cfg_t       cfg_i,
  input  logic                 empty_i,
  input  scfd_pkg::cmd_t       cmd_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output scfd_pkg::duty_vec_t  out_duty_o,
  output logic                 out_done_o,
  output logic                 out_timeout_o
);

  scfd_pkg::duty_vec_t           duties_q, duties_d;
  logic [scfd_pkg::CountW-1:0]   count_q, count_d;
  logic [scfd_pkg::CountW:0]     count_inc;
  logic                          done_d, tout_d;
  logic                          done_q, tout_q;
  logic                          valid_q;

  // Duties only change on a pop, which also reloads the output slot, so the
  // duty registers double as the output payload.
  assign pop_o         = !empty_i && (!valid_q || out_ready_i);
  assign out_valid_o   = valid_q;
  assign out_duty_o    = duties_q;
  assign out_done_o    = done_q;
  assign out_timeout_o = tout_q;
  assign count_inc     = {1'b0, count_q} + 1'b1;

  always_comb begin
    duties_d = duties_q;
    count_d  = count_q;
    done_d   = 1'b0;
    tout_d   = 1'b0;
    unique case (cmd_i.kind)
      scfd_pkg::CmdSet: begin
        duties_d[cmd_i.ch] = scfd_pkg::clamp_duty(scfd_pkg::DutyW'(cmd_i.value), cfg_i);
        done_d             = 1'b1;
      end
      scfd_pkg::CmdTick: begin
        if (count_inc >= {1'b0, cfg_i.timeout_ticks}) begin
          for (int i = 0; i < scfd_pkg::NumChannels; i++) begin
            duties_d[i] = scfd_pkg::clamp_duty('0, cfg_i);
          end
          count_d = '0;
          tout_d  = 1'b1;
        end else begin
          count_d = count_inc[scfd_pkg::CountW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duties_q <= '0;
      count_q  <= '0;
      done_q   <= 1'b0;
      tout_q   <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        duties_q <= duties_d;
        count_q  <= count_d;
        done_q   <= done_d;
        tout_q   <= tout_d;
        valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        valid_q  <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/servo_command_frame_decoder.sv =====
// Servo command frame decoder.
// Input stream: one beat per serial byte or timer tick. s_axis_tuser[0] is
// the kind (0 byte, 1 tick); s_axis_tdata carries the byte, ignored on ticks.
// A command frame is two bytes: a header (bit 7 set, bits 6:5 = device id,
// bits 4:3 channel, bit 0 duty bit 7) and a data byte (bits 6:0 = duty 6:0).
// Output stream: exactly one beat per input beat, carrying all four channel
// duties after that beat, plus flags: frame_done (a frame updated a channel)
// and timed_out (the tick count reached timeout_ticks, all duties set off).
// Configuration: write port cfg_valid_i/cfg_index_i/cfg_data_i, always ready;
// write only while no beat is in flight. Out-of-range indices are ignored.
// The command queue holds each beat until the execute stage, which owns the
// duty registers, pops it and loads its result into the output slot, which
// offers it until taken. Throughput: one beat per cycle while the output is
// not stalled; the two-entry command queue between the classifier and the
// execute stage plus the output slot absorb three beats while the output is
// stalled. When m_axis_tready is low, the output beat holds, the queue fills
// and s_axis_tready drops once both entries are taken.
// Reset: registers return to their defaults (device id 0, lock off, min 0,
// max 1023, timeout 255), duties and the tick count clear, no header pending.
module servo_command_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic [0:0]  s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [9:0] duty_ch0, [19:10] duty_ch1,
                                      // [29:20] duty_ch2, [39:30] duty_ch3
  output logic [1:0]  m_axis_tuser,   // [0] frame_done, [1] timed_out
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [scfd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [scfd_pkg::CfgDataW-1:0] cfg_data_i
);

  scfd_pkg::cfg_t      cfg_q;
  logic                push, full, pop, empty;
  scfd_pkg::cmd_t      push_cmd, pop_cmd;
  scfd_pkg::duty_vec_t duties;
  logic                done, tout;

  assign cfg_ready_o = 1'b1;

  // Configuration registers; masked to their widths.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_id     <= '0;
      cfg_q.lock_enable   <= 1'b0;
      cfg_q.duty_min      <= '0;
      cfg_q.duty_max      <= '1;
      cfg_q.timeout_ticks <= '1;
    end else if (cfg_valid_i) begin
      unique case (scfd_pkg::reg_idx_e'(cfg_index_i))
        scfd_pkg::RegDeviceId:     cfg_q.device_id     <= cfg_data_i[scfd_pkg::DevIdW-1:0];
        scfd_pkg::RegLockEnable:   cfg_q.lock_enable   <= cfg_data_i[0];
        scfd_pkg::RegDutyMin:      cfg_q.duty_min      <= cfg_data_i[scfd_pkg::DutyW-1:0];
        scfd_pkg::RegDutyMax:      cfg_q.duty_max      <= cfg_data_i[scfd_pkg::DutyW-1:0];
        scfd_pkg::RegTimeoutTicks: cfg_q.timeout_ticks <= cfg_data_i[scfd_pkg::CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: classify bytes into commands, track the pending header.
  scfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (s_axis_tuser[0]),
    .in_byte_i  (s_axis_tdata),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (full)
  );

  // Decouple classification from execution.
  scfd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_cmd_o  (pop_cmd)
  );

  // Back: apply clamps, run the timeout counter, hold the output beat.
  scfd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .empty_i       (empty),
    .cmd_i         (pop_cmd),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_duty_o    (duties),
    .out_done_o    (done),
    .out_timeout_o (tout)
  );

  assign m_axis_tdata = duties;
  assign m_axis_tuser = {tout, done};

  // A beat never carries both a frame completion and a timeout.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("frame_done and timed_out set together");

  // A timeout beat shows every channel at the same off duty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |->
      (duties[0] == duties[1] && duties[1] == duties[2] && duties[2] == duties[3]))
    else $error("timeout left channels with differing duties");

  // A pop never happens on an empty queue, and a push never on a full one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && empty) && !(push && full))
    else $error("command queue overrun or underrun");

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import scfd_pkg::*;

  localparam int unsigned ClkPeriod     = 4;
  localparam int unsigned ResetCycles   = 11;
  localparam int unsigned IdleSettle    = 4;   // two-stage pipe plus margin
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned PhaseItems    = 320;
  localparam int unsigned HoldCycles    = 150;
  localparam int unsigned PressureItems = 24;

  // First index past the register map; writes there must change nothing.
  localparam logic [CfgIdxW-1:0] FirstUnusedIdx = CfgIdxW'(RegTimeoutTicks) + 1'b1;

  // One output beat: every channel duty plus the two event flags.
  typedef struct packed {
    duty_vec_t duty;
    logic      frame_done;
    logic      timed_out;
  } servo_beat_t;

  // ---------------------------------------------------------------------------
  // Clock, DUT signals and instance
  // ---------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // [7:0] byte_value
  logic [0:0]          s_axis_tuser;   // [0] op
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [39:0]         m_axis_tdata;   // [9:0] ch0, [19:10] ch1, [29:20] ch2, [39:30] ch3
  logic [1:0]          m_axis_tuser;   // [0] frame_done, [1] timed_out
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  servo_command_frame_decoder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the decoder: registers and state, as after reset
  // ---------------------------------------------------------------------------
  logic [DevIdW-1:0] sh_dev_id    = '0;
  logic              sh_lock      = 1'b0;
  logic [DutyW-1:0]  sh_duty_min  = '0;
  logic [DutyW-1:0]  sh_duty_max  = '1;
  logic [CountW-1:0] sh_timeout   = '1;

  logic [ByteW-1:0]  hdr_byte     = '0;
  logic              hdr_pending  = 1'b0;
  logic [DutyW-1:0]  duty_mirror [MaxChannels] = '{default: '0};
  logic [CountW-1:0] tick_count   = '0;

  servo_beat_t duty_expect_q[$];

  // Traffic shaping, changed per phase by the test tasks.
  int unsigned tx_gap_pct   = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold_left = 0;
  int unsigned tick_pct     = 20;

  int unsigned error_count  = 0;
  int unsigned beats_in     = 0;
  int unsigned beats_out    = 0;
  int unsigned frames_seen  = 0;
  int unsigned timeouts_seen = 0;
  int unsigned idle_cycles  = 0;

  // Lock on: the lower bound is tested first, so when min > max it wins only below min.
  function automatic logic [DutyW-1:0] limit_duty(logic [DutyW-1:0] v);
    if (sh_lock) begin
      if (v < sh_duty_min) return sh_duty_min;
      if (v > sh_duty_max) return sh_duty_max;
    end
    return v;
  endfunction

  // Advance the shadow state by one accepted input beat and return the
  // output beat it must produce.
  function automatic servo_beat_t predict_servo_beat(op_e op, logic [ByteW-1:0] b);
    servo_beat_t      r;
    int unsigned      ch;
    int unsigned      ticks_next;
    logic [DutyW-1:0] off;
    r = '0;
    if (op == OpByte) begin
      if (!hdr_pending) begin
        // Drop anything that is not a header addressed to this device.
        if (b[HdrFlagBit] && b[HdrIdHi:HdrIdLo] == sh_dev_id) begin
          hdr_byte    = b;
          hdr_pending = 1'b1;
        end
      end else begin
        // Any byte completes the frame, even one that looks like a header.
        ch = hdr_byte[HdrChHi:HdrChLo];
        if (ch < NumChannels) begin
          duty_mirror[ch] = limit_duty({2'b00, hdr_byte[HdrValBit], b[ByteW-2:0]});
          r.frame_done = 1'b1;
        end
        hdr_pending = 1'b0;
      end
    end else begin
      // Frames never restart the count; only a timeout clears it.
      ticks_next = tick_count + 1;
      if (ticks_next >= sh_timeout) begin
        off = limit_duty('0);
        for (int i = 0; i < NumChannels; i++) duty_mirror[i] = off;
        tick_count  = '0;
        r.timed_out = 1'b1;
      end else begin
        tick_count = ticks_next[CountW-1:0];
      end
    end
    for (int i = 0; i < MaxChannels; i++) begin
      r.duty[i] = (i < NumChannels) ? duty_mirror[i] : '0;
    end
    return r;
  endfunction

  function automatic void apply_reg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      RegDeviceId:     sh_dev_id   = data[DevIdW-1:0];
      RegLockEnable:   sh_lock     = data[0];
      RegDutyMin:      sh_duty_min = data[DutyW-1:0];
      RegDutyMax:      sh_duty_max = data[DutyW-1:0];
      RegTimeoutTicks: sh_timeout  = data[CountW-1:0];
      default: ;  // unmapped index: no effect
    endcase
  endfunction

  function automatic logic [ByteW-1:0] make_header(logic [DevIdW-1:0] id, logic [ChW-1:0] ch,
                                                   logic val_msb, logic [1:0] filler);
    return {1'b1, id, ch, filler, val_msb};
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: drive at the falling edge, detect acceptance at the rising edge
  // ---------------------------------------------------------------------------
  task automatic send_beat(op_e op, logic [ByteW-1:0] b);
    servo_beat_t exp_beat;
    // Insert random idle cycles; valid stays low across each of them.
    while ($urandom_range(99) < tx_gap_pct) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tuser  = op;
    do @(posedge clk_i); while (!s_axis_tready);
    exp_beat = predict_servo_beat(op, b);
    duty_expect_q.push_back(exp_beat);
    beats_in++;
    if (exp_beat.frame_done) frames_seen++;
    if (exp_beat.timed_out)  timeouts_seen++;
  endtask

  task automatic send_frame(logic [ByteW-1:0] hdr, logic [ByteW-1:0] data);
    send_beat(OpByte, hdr);
    send_beat(OpByte, data);
  endtask

  task automatic end_of_burst();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Hold until every expected beat has come back and the pipe is empty.
  task automatic wait_idle();
    while (duty_expect_q.size() != 0) @(posedge clk_i);
    repeat (IdleSettle) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg_write(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Write the whole map; unused upper data bits carry junk to exercise masking.
  task automatic write_all_regs(logic [DevIdW-1:0] id, logic lock, logic [DutyW-1:0] dmin,
                                logic [DutyW-1:0] dmax, logic [CountW-1:0] tmo);
    write_reg(RegDeviceId,     {8'($urandom_range(255)), id});
    write_reg(RegLockEnable,   {9'($urandom_range(511)), lock});
    write_reg(RegDutyMin,      dmin);
    write_reg(RegDutyMax,      dmax);
    write_reg(RegTimeoutTicks, {2'($urandom_range(3)), tmo});
  endtask

  // Mostly well-formed frames with random content, some ticks and some noise.
  task automatic send_random(int unsigned n);
    int unsigned      sent;
    int unsigned      pick;
    logic [DevIdW-1:0] id;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < tick_pct) begin
        send_beat(OpTick, 8'($urandom_range(255)));
        sent++;
      end else if (pick < 92) begin
        id = ($urandom_range(9) == 0) ? DevIdW'($urandom_range(3)) : sh_dev_id;
        send_frame(make_header(id, ChW'($urandom_range(3)), 1'($urandom_range(1)),
                               2'($urandom_range(3))),
                   8'($urandom_range(255)));
        sent += 2;
      end else begin
        send_beat(OpByte, 8'($urandom_range(255)));
      end
    end
    end_of_burst();
  endtask

  // ---------------------------------------------------------------------------
  // Output side: ready changes at the falling edge; a long hold-off is counted
  // down here, independent of the sender
  // ---------------------------------------------------------------------------
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        m_axis_tready = 1'b0;
        rx_hold_left--;
      end else begin
        m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted beat with the oldest expectation
  // ---------------------------------------------------------------------------
  servo_beat_t got_beat;
  servo_beat_t want_beat;

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    error_count++;
    if (error_count <= MaxReports) begin
      $display("[%0t] output beat %0d: %s expected %0d, got %0d",
               $realtime, beats_out, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_beat.duty       = m_axis_tdata;
      got_beat.frame_done = m_axis_tuser[0];
      got_beat.timed_out  = m_axis_tuser[1];
      if (duty_expect_q.size() == 0) begin
        report_mismatch("beat with none pending, count", 0, 1);
      end else begin
        want_beat = duty_expect_q.pop_front();
        for (int ch = 0; ch < MaxChannels; ch++) begin
          if (got_beat.duty[ch] !== want_beat.duty[ch]) begin
            report_mismatch($sformatf("duty_ch%0d", ch), want_beat.duty[ch], got_beat.duty[ch]);
          end
        end
        if (got_beat.frame_done !== want_beat.frame_done) begin
          report_mismatch("frame_done", want_beat.frame_done, got_beat.frame_done);
        end
        if (got_beat.timed_out !== want_beat.timed_out) begin
          report_mismatch("timed_out", want_beat.timed_out, got_beat.timed_out);
        end
      end
      beats_out++;
    end
  end

  // Watchdog: any beat or register write on any channel counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("stalled for %0d cycles with %0d beats pending",
               idle_cycles, duty_expect_q.size());
      $display("servo_command_frame_decoder test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: device 0, lock off. Cover dropped bytes, field extremes
  // and a header byte arriving where the data byte belongs.
  task automatic test_frame_basics();
    send_beat(OpTick, 8'hFF);                       // byte ignored on a tick
    send_beat(OpByte, 8'h7F);                       // top bit clear: drop
    send_beat(OpByte, make_header(2'd1, 2'd0, 1'b1, 2'b11));  // wrong device: drop
    send_frame(make_header(2'd0, 2'd0, 1'b1, 2'b00), 8'hFF);  // value 255, data msb ignored
    send_frame(make_header(2'd0, 2'd3, 1'b0, 2'b11), 8'h00);  // value 0 on the last channel
    send_frame(make_header(2'd0, 2'd1, 1'b0, 2'b00), 8'h80);  // header-like data byte
    end_of_burst();
    wait_idle();
  endtask

  // Lock on: clamp below min and above max, then min above max.
  task automatic test_lock_clamp();
    write_reg(RegDeviceId,   10'h3FF);              // masks to device 3
    write_reg(RegLockEnable, 10'h2A5);              // masks to 1
    write_reg(RegDutyMin,    10'd100);
    write_reg(RegDutyMax,    10'd200);
    send_frame(make_header(2'd3, 2'd0, 1'b0, 2'b01), 8'h80);  // 0 -> min
    send_frame(make_header(2'd3, 2'd1, 1'b1, 2'b10), 8'h7F);  // 255 -> max
    end_of_burst();
    wait_idle();
    write_reg(RegDutyMin, 10'd300);
    write_reg(RegDutyMax, 10'd0);
    send_frame(make_header(2'd3, 2'd2, 1'b1, 2'b00), 8'h16);  // 150: min wins
    send_beat(OpTick, 8'h00);
    end_of_burst();
    wait_idle();
  endtask

  // Timeout on every tick, then lower the limit under the running count.
  task automatic test_tick_timeout();
    write_reg(RegTimeoutTicks, 10'h301);            // masks to 1
    send_beat(OpTick, 8'h5A);
    end_of_burst();
    wait_idle();
    write_reg(RegTimeoutTicks, 10'd40);
    repeat (3) send_beat(OpTick, 8'($urandom_range(255)));
    end_of_burst();
    wait_idle();
    write_reg(RegTimeoutTicks, 10'd2);
    send_beat(OpTick, 8'hA5);
    end_of_burst();
    wait_idle();
  endtask

  // Writes past the register map must leave every register untouched.
  task automatic test_unused_index();
    for (int idx = FirstUnusedIdx; idx < (1 << CfgIdxW); idx++) begin
      write_reg(CfgIdxW'(idx), (idx % 2) ? 10'h3FF : 10'h000);
    end
    send_frame(make_header(sh_dev_id, 2'd3, 1'b0, 2'b01), 8'h55);
    end_of_burst();
    wait_idle();
  endtask

  // Four idling mixes, each with its own register setting.
  task automatic test_random_phases();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          tx_gap_pct = 0;  rx_stall_pct = 0;  tick_pct = 15;
          write_all_regs(2'd0, 1'b0, 10'd0, 10'd1023, 8'd255);
        end
        1: begin
          tx_gap_pct = 73; rx_stall_pct = 0;  tick_pct = 25;
          write_all_regs(2'd3, 1'b1, 10'd0, 10'd1023, 8'($urandom_range(1, 8)));
        end
        2: begin
          tx_gap_pct = 0;  rx_stall_pct = 73; tick_pct = 25;
          write_all_regs(2'($urandom_range(3)), 1'b1, 10'($urandom_range(1023)),
                         10'($urandom_range(1023)), 8'($urandom_range(1, 40)));
        end
        default: begin
          tx_gap_pct = 19; rx_stall_pct = 19; tick_pct = 20;
          write_all_regs(2'd1, 1'($urandom_range(1)), 10'd1023, 10'd1023,
                         8'($urandom_range(1, 20)));
        end
      endcase
      send_random(PhaseItems);
      wait_idle();
    end
  endtask

  // Hold the output off for a long stretch while the sender keeps offering,
  // so the command queue fills and input ready drops.
  task automatic test_output_backpressure();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    tick_pct     = 30;
    write_all_regs(2'd2, 1'b1, 10'd20, 10'd230, 8'd5);
    rx_hold_left = HoldCycles;
    send_random(PressureItems);
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OpByte;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_frame_basics();
    test_lock_clamp();
    test_tick_timeout();
    test_unused_index();
    test_random_phases();
    test_output_backpressure();

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (duty_expect_q.size() != 0) begin
      error_count += duty_expect_q.size();
      $display("%0d expected beats never arrived", duty_expect_q.size());
    end

    $display("Ran %0d input beats, %0d output beats: %0d completed frames, %0d timeouts,",
             beats_in, beats_out, frames_seen, timeouts_seen);
    $display("four idle/stall mixes, a long output hold-off and %0d mismatches.", error_count);
    if (error_count == 0) begin
      $display("servo_command_frame_decoder test passed");
    end else begin
      $display("servo_command_frame_decoder test failed");
    end
    $finish;
  end

endmodule
